// ===== rtl/core/dotq_pkg.sv =====
// dotq_pkg: shared types and codes for the deadline ordered task queue
// used by deadline_ordered_task_queue and the tb bench
`default_nettype none
package dotq_pkg;
   localparam int unsigned RecordWidth = 161;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_LOOKUP = 2'd1,
      ACT_REMOVE = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_NOTFOUND = 2'd1,
      ST_FULL     = 2'd2,
      ST_RSVD     = 2'd3
   } status_type;

   typedef struct packed {
      logic [31:0] completion;
      logic [31:0] release_t;
      logic        kind;
      logic [31:0] handle;
      logic [31:0] deadline;
      logic [31:0] id;
   } record_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT_UP,
      S_SHIFT_DOWN,
      S_OUT
   } state_type;
endpackage
`default_nettype wire

// ===== rtl/core/dotq_ram.sv =====
// dotq_ram: generic single write port ram with registered read
// no dependencies
`default_nettype none
module dotq_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== rtl/core/deadline_ordered_task_queue.sv =====
// deadline_ordered_task_queue: sorted earliest deadline first task table
// depends on dotq_pkg and dotq_ram
//
// usage: requests come in on req_ (tvalid/tready/tdata), one response per
// request leaves on rsp_. records sit in one ram in deadline order, slot 0 is
// the head. a request is taken only while the block is idle.
// insert: one read per slot scanned from the tail down, each slot with a
//   deadline not below the new one moves up by one.
// lookup: slots read from the head until a match.
// remove: lookup, then each following slot moves down by one.
// the record ram has a single read and a single write port, so slots are
// read and moved one at a time.
// reset clears the count and control state; ram contents need no clearing.
// a stalled rsp_ keeps the response in its output register; the next request
// is taken once the response has left.
`default_nettype none
module deadline_ordered_task_queue #(
   parameter int unsigned CAPACITY = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // action[1:0], task_id[33:2], deadline[65:34], handle[97:66],
   // task_kind[98], release_at[130:99], finish_at[162:131], zero pad
   input  wire logic [167:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // status[1:0], found_id[33:2], found_deadline[65:34], found_handle[97:66],
   // found_kind[98], found_release[130:99], found_completion[162:131],
   // entry_count[167:163]
   output logic [167:0]      rsp_tdata
);
   import dotq_pkg::*;

   localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CW = $clog2(CAPACITY + 1);

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    idx_ff, idx_in;
   logic             rd_wait_ff, rd_wait_in;
   action_type       act_ff, act_in;
   record_type       req_rec_ff, req_rec_in;
   record_type       out_rec_ff, out_rec_in;
   status_type       status_ff, status_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             wr_en;
   logic [AW-1:0]    wr_addr, rd_addr;
   record_type       wr_data, rd_data;

   dotq_ram #(.Width(RecordWidth), .Depth(CAPACITY)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rd_wait_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_wait_ff   <= rd_wait_in;
      end
      idx_ff     <= idx_in;
      act_ff     <= act_in;
      req_rec_ff <= req_rec_in;
      out_rec_ff <= out_rec_in;
      status_ff  <= status_in;
   end

   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'(count_ff), out_rec_ff, status_ff};

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rd_wait_in   = 1'b0;
      act_in       = act_ff;
      req_rec_in   = req_rec_ff;
      out_rec_in   = out_rec_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      wr_en        = 1'b0;
      wr_addr      = idx_ff[AW-1:0];
      wr_data      = rd_data;
      rd_addr      = idx_ff[AW-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               act_in     = action_type'(req_tdata[1:0]);
               req_rec_in = record_type'(req_tdata[162:2]);
               out_rec_in = '0;
               unique case (action_type'(req_tdata[1:0]))
                  ACT_INSERT: begin
                     if (count_ff == CW'(CAPACITY)) begin
                        status_in = ST_FULL;
                        state_in  = S_OUT;
                     end else if (count_ff == '0) begin
                        idx_in   = '0;
                        state_in = S_SHIFT_UP;
                     end else begin
                        // read from the tail slot down
                        idx_in     = count_ff - 1'b1;
                        rd_wait_in = 1'b1;
                        state_in   = S_SHIFT_UP;
                     end
                  end
                  ACT_LOOKUP, ACT_REMOVE: begin
                     idx_in     = '0;
                     rd_wait_in = (count_ff != '0);
                     status_in  = ST_NOTFOUND;
                     state_in   = (count_ff == '0) ? S_OUT : S_SCAN;
                  end
                  default: begin
                     status_in = ST_NOTFOUND;
                     state_in  = S_OUT;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (!rd_wait_ff) begin
               if (rd_data.id == req_rec_ff.id) begin
                  out_rec_in = rd_data;
                  status_in  = ST_DONE;
                  if (act_ff == ACT_REMOVE) begin
                     idx_in     = idx_ff + 1'b1;
                     rd_wait_in = (idx_ff + 1'b1 < count_ff);
                     state_in   = S_SHIFT_DOWN;
                  end else begin
                     state_in = S_OUT;
                  end
               end else if (idx_ff + 1'b1 >= count_ff) begin
                  state_in = S_OUT;
               end else begin
                  idx_in     = idx_ff + 1'b1;
                  rd_wait_in = 1'b1;
               end
            end
         end
         S_SHIFT_DOWN: begin
            // idx_ff is the slot read; it moves to idx_ff - 1
            if (idx_ff >= count_ff) begin
               count_in  = count_ff - 1'b1;
               state_in  = S_OUT;
            end else if (!rd_wait_ff) begin
               wr_en      = 1'b1;
               wr_addr    = AW'(idx_ff - 1'b1);
               wr_data    = rd_data;
               idx_in     = idx_ff + 1'b1;
               rd_wait_in = (idx_ff + 1'b1 < count_ff);
            end
         end
         S_SHIFT_UP: begin
            // idx_ff is the slot read, or the insert slot when no read waits
            if (rd_wait_ff) begin
               rd_wait_in = 1'b0;
            end else if (idx_ff < count_ff && !(rd_data.deadline < req_rec_ff.deadline)
                         && state_ff == S_SHIFT_UP && act_ff == ACT_INSERT
                         && idx_ff != count_ff) begin
               wr_en   = 1'b1;
               wr_addr = AW'(idx_ff + 1'b1);
               wr_data = rd_data;
               if (idx_ff == '0) begin
                  idx_in = CW'(CAPACITY); // marks insert at head
                  state_in = S_SHIFT_UP;
                  act_in   = ACT_NONE;
               end else begin
                  idx_in     = idx_ff - 1'b1;
                  rd_wait_in = 1'b1;
               end
            end else begin
               // write new record: above idx_ff, at idx_ff when empty, head when marked
               wr_en    = 1'b1;
               wr_data  = req_rec_ff;
               if (act_ff == ACT_NONE || count_ff == '0) begin
                  wr_addr = '0;
               end else begin
                  wr_addr = AW'(idx_ff + 1'b1);
               end
               count_in  = count_ff + 1'b1;
               status_in = ST_DONE;
               state_in  = S_OUT;
            end
         end
         S_OUT: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("count above capacity");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff != S_IDLE))
      else $error("request taken without work");
   a_full_no_grow: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] == ST_FULL) |-> (count_ff == CW'(CAPACITY)))
      else $error("full status with room left");
`endif
endmodule
`default_nettype wire

// ===== test/tb.sv =====
// tb: self-checking bench for deadline_ordered_task_queue
// depends on dotq_pkg and the queue rtl; a scoreboard class predicts each response
`default_nettype none
module tb;
   import dotq_pkg::*;

   localparam int unsigned Depth = 16;
   localparam int unsigned CycleLimit = 400000;

   typedef struct packed {
      logic [31:0] completion;
      logic [31:0] release_t;
      logic        kind;
      logic [31:0] handle;
      logic [31:0] deadline;
      logic [31:0] id;
   } task_rec_type;

   typedef struct {
      status_type    status;
      task_rec_type  rec;
      logic [4:0]    count;
   } queue_answer_type;

   class edf_scoreboard_type;
      task_rec_type     slots[$];
      queue_answer_type pending[$];
      int               errors;

      function void note_request(logic [167:0] d);
         action_type       act;
         task_rec_type     r;
         queue_answer_type a;
         int               pos;
         act = action_type'(d[1:0]);
         r.id = d[33:2];
         r.deadline = d[65:34];
         r.handle = d[97:66];
         r.kind = d[98];
         r.release_t = d[130:99];
         r.completion = d[162:131];
         a.rec = '0;
         a.status = ST_NOTFOUND;
         if (act == ACT_INSERT) begin
            if (slots.size() >= Depth) begin
               a.status = ST_FULL;
            end else begin
               pos = 0;
               while (pos < slots.size() && slots[pos].deadline < r.deadline) pos++;
               slots.insert(pos, r);
               a.status = ST_DONE;
            end
         end else if (act == ACT_LOOKUP || act == ACT_REMOVE) begin
            pos = -1;
            foreach (slots[i]) if (pos < 0 && slots[i].id == r.id) pos = i;
            if (pos >= 0) begin
               a.status = ST_DONE;
               a.rec = slots[pos];
               if (act == ACT_REMOVE) slots.delete(pos);
            end
         end
         a.count = 5'(slots.size());
         pending.push_back(a);
      endfunction

      function void check_response(logic [167:0] d);
         queue_answer_type e;
         if (pending.size() == 0) begin
            $error("response with nothing pending: %h", d);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (d[1:0] !== e.status) begin
            $error("status expected %0d actual %0d", e.status, d[1:0]); errors++;
         end
         if (d[33:2] !== e.rec.id) begin
            $error("found_id expected %h actual %h", e.rec.id, d[33:2]); errors++;
         end
         if (d[65:34] !== e.rec.deadline) begin
            $error("found_deadline expected %h actual %h", e.rec.deadline, d[65:34]);
            errors++;
         end
         if (d[97:66] !== e.rec.handle) begin
            $error("found_handle expected %h actual %h", e.rec.handle, d[97:66]);
            errors++;
         end
         if (d[98] !== e.rec.kind) begin
            $error("found_kind expected %b actual %b", e.rec.kind, d[98]); errors++;
         end
         if (d[130:99] !== e.rec.release_t) begin
            $error("found_release expected %h actual %h", e.rec.release_t, d[130:99]);
            errors++;
         end
         if (d[162:131] !== e.rec.completion) begin
            $error("found_completion expected %h actual %h", e.rec.completion,
                   d[162:131]);
            errors++;
         end
         if (d[167:163] !== e.count) begin
            $error("entry_count expected %0d actual %0d", e.count, d[167:163]);
            errors++;
         end
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [167:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [167:0] rsp_tdata;

   edf_scoreboard_type board = new();
   int  send_idle_pct = 19;
   int  recv_idle_pct = 72;
   bit  recv_hold = 0;
   int  cycles = 0;
   int  id_pool[$];

   deadline_ordered_task_queue #(.CAPACITY(Depth)) i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // responses are checked at the edge that accepts them
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);
         rsp_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic logic [31:0] pick_id();
      if (id_pool.size() > 0 && $urandom_range(3) != 0)
         return id_pool[$urandom_range(id_pool.size() - 1)];
      return $urandom_range(7);
   endfunction

   // tvalid stays high after a request is taken until the next one replaces it
   // or the sender idles
   task automatic send_request(action_type act, logic [31:0] id, logic [31:0] dl,
                               logic [31:0] h, logic k, logic [31:0] rel,
                               logic [31:0] comp);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {5'd0, comp, rel, k, h, dl, id, act};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(req_tdata);
      if (act == ACT_INSERT) id_pool.push_back(id);
   endtask

   task automatic send_random(bit noisy);
      action_type  act;
      logic [31:0] dl;
      int          r;
      r = $urandom_range(99);
      if (noisy && r < 5) act = ACT_NONE;
      else if (r < 50) act = ACT_INSERT;
      else if (r < 70) act = ACT_LOOKUP;
      else act = ACT_REMOVE;
      // small deadline range so equal deadlines occur often
      dl = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(20);
      send_request(act, (act == ACT_INSERT && $urandom_range(1)) ? $urandom() : pick_id(),
                   dl, $urandom(), 1'($urandom_range(1)), $urandom(), $urandom());
   endtask

   task automatic wait_drained();
      req_tvalid <= 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: empty lookups, extremes, equal deadlines, duplicates, fill
      send_request(ACT_LOOKUP, 0, 0, 0, 0, 0, 0);
      send_request(ACT_REMOVE, '1, 0, 0, 0, 0, 0);
      send_request(ACT_NONE, '1, '1, '1, 1, '1, '1);
      send_request(ACT_INSERT, '1, '1, '1, 1, '1, '1);
      send_request(ACT_INSERT, 0, 0, 0, 0, 0, 0);
      send_request(ACT_INSERT, 5, 100, 32'haaaa5555, 1, 32'h5555aaaa, 32'h12345678);
      send_request(ACT_INSERT, 5, 100, 32'h5555aaaa, 0, 32'haaaa5555, 32'h87654321);
      send_request(ACT_LOOKUP, 5, 0, 0, 0, 0, 0);
      send_request(ACT_REMOVE, 5, 0, 0, 0, 0, 0);
      send_request(ACT_LOOKUP, 5, 0, 0, 0, 0, 0);
      send_request(ACT_LOOKUP, '1, 0, 0, 0, 0, 0);
      for (int i = 0; i < 14; i++)
         send_request(ACT_INSERT, 32'h100 + i, $urandom_range(300), $urandom(),
                      1'($urandom_range(1)), $urandom(), $urandom());
      send_request(ACT_INSERT, 99, 50, 1, 1, 1, 1);
      send_request(ACT_REMOVE, 0, 0, 0, 0, 0, 0);
      send_request(ACT_NONE, 0, 0, 0, 0, 0, 0);
      wait_drained();
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 72 : 0;
         recv_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 19 : 0;
         for (int n = 0; n < 500; n++) begin
            send_random(n % 10 == 0);
            if (n == 250 && phase == 2) wait_drained();
         end
      end
      wait_drained();
      repeat (60) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // long receiver hold-off while requests keep coming
   initial begin
      repeat (3000) @(posedge clock);
      recv_hold = 1;
      repeat (400) @(posedge clock);
      recv_hold = 0;
   end
endmodule
`default_nettype wire
